>>> design/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS = 5;
  localparam int WAYS = 8;
  localparam int ADDR_WIDTH = 64;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NWAYS_W = $clog2(WAYS + 1) + 1;

  localparam int RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam int SET_CFG_W = 3;
  localparam int WAYS_CFG_W = 4;
  localparam int BLOCK_CFG_W = 6;
  localparam int SHIFT_W = BLOCK_CFG_W + 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam int CNT_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_IFETCH = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [ADDR_WIDTH-1:0] address;
  } req_t;

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_evict;
    logic             second_hit;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } rsp_t;

  typedef struct packed {
    logic [SET_CFG_W-1:0]   set_bits;
    logic [WAYS_CFG_W-1:0]  ways_in_use;
    logic [BLOCK_CFG_W-1:0] block_bits;
  } cfg_t;

  typedef struct packed {
    func_t                 func;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } qhead_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> design/set_assoc_lru_cache_model.sv
// Set-associative cache model with LRU replacement.
// Requests enter through a queue-style port: drive req and push, and the
// request is taken on a clock edge where full is low. Each request yields
// exactly one response, in order, shown on rsp while empty is low and
// consumed on a clock edge where pop is high.
// Configuration (set_bits, ways_in_use, block_bits) is written through the
// cfg_valid/cfg_ready channel, indexed by cfg_index; cfg_ready is always
// high. Write it only while no request is in flight.
// A taken request passes from the queue through the set memory read into
// the compare/update/write-back step, which sets rsp and waits for pop while
// a response is unconsumed; no new request is read before that step ends.
// A two-entry request queue in front lets two requests be taken while a
// response sits unconsumed; when the consumer stalls, the queue fills and
// full rises. Reset clears every line valid bit and the running totals, and
// restores set_bits 0, ways_in_use 1, block_bits 0; no clearing pass is
// needed, requests are taken as soon as reset is released.
module set_assoc_lru_cache_model (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  salc_pkg::req_t                    req,
  output logic                              empty,
  input  logic                              pop,
  output salc_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [salc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import salc_pkg::*;

  cfg_t   cfg;
  qhead_t head;
  logic   head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits <= '0;
      cfg.ways_in_use <= WAYS_CFG_W'(1);
      cfg.block_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_BITS:    cfg.set_bits <= cfg_data[SET_CFG_W-1:0];
        CFG_WAYS_IN_USE: cfg.ways_in_use <= cfg_data[WAYS_CFG_W-1:0];
        CFG_BLOCK_BITS:  cfg.block_bits <= cfg_data[BLOCK_CFG_W-1:0];
        default: cfg <= cfg;
      endcase
    end
  end

  salc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .cfg      (cfg),
    .head     (head),
    .head_pop (head_pop)
  );

  salc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_pop    (head_pop),
    .ways_in_use (cfg.ways_in_use),
    .empty       (empty),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

>>> design/salc_front.sv
module salc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  salc_pkg::req_t  req,
  input  salc_pkg::cfg_t  cfg,
  output salc_pkg::qhead_t head,
  input  logic            head_pop
);
  import salc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  work_t               queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_QW-1:0]   count;

  logic [SET_CFG_W:0]    s_eff;
  logic [SHIFT_W-1:0]    tag_shift;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W-1:0]      set_mask;
  work_t                 incoming;
  logic                  do_push;

  // Split the address: offset below, set index in the middle, tag above.
  always_comb begin
    if ({1'b0, cfg.set_bits} > (SET_CFG_W + 1)'(MAX_SET_BITS)) begin
      s_eff = (SET_CFG_W + 1)'(MAX_SET_BITS);
    end else begin
      s_eff = {1'b0, cfg.set_bits};
    end
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = ((SET_CFG_W + 1)'(i) < s_eff);
    end
    shifted = req.address >> cfg.block_bits;
    tag_shift = {1'b0, cfg.block_bits} + SHIFT_W'(s_eff);
    incoming.func = req.func;
    incoming.set_idx = shifted[SET_W-1:0] & set_mask;
    incoming.tag = req.address >> tag_shift;
  end

  assign full = (count == CNT_QW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign head.valid = (count != '0);
  assign head.item = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, head_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/salc_back.sv
module salc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  salc_pkg::qhead_t                 head,
  output logic                             head_pop,
  input  logic [salc_pkg::WAYS_CFG_W-1:0]  ways_in_use,
  output logic                             empty,
  input  logic                             pop,
  output salc_pkg::rsp_t                   rsp
);
  import salc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  logic [WAYS*ADDR_WIDTH-1:0] tag_mem  [NUM_SETS];
  logic [WAYS*RANK_W-1:0]     rank_mem [NUM_SETS];
  logic [WAYS-1:0]            valid    [NUM_SETS];

  state_t                     state;
  work_t                      work;
  logic [WAYS*ADDR_WIDTH-1:0] tag_row;
  logic [WAYS*RANK_W-1:0]     rank_row;
  logic [CNT_W-1:0]           hits;
  logic [CNT_W-1:0]           misses;
  logic [CNT_W-1:0]           evicts;
  logic                       out_valid;

  logic [NWAYS_W-1:0]         nways;
  logic [WAYS-1:0]            in_use;
  logic [WAYS-1:0]            vrow;
  logic [RANK_W-1:0]          rank     [WAYS];
  logic [WAYS-1:0]            hit_vec;
  logic                       hit;
  logic [WAY_W-1:0]           hit_way;
  logic                       found_empty;
  logic [WAY_W-1:0]           empty_way;
  logic [WAY_W-1:0]           max_way;
  logic [WAY_W-1:0]           target;
  logic [RANK_W-1:0]          hit_rank;
  logic                       evict;
  logic                       is_acc;
  logic [WAYS*RANK_W-1:0]     rank_new;
  logic [WAYS*ADDR_WIDTH-1:0] tag_new;
  logic                       done;
  rsp_t                       rsp_next;
  logic [CNT_W-1:0]           hits_next;
  logic [CNT_W-1:0]           misses_next;
  logic [CNT_W-1:0]           evicts_next;

  assign head_pop = (state == ST_IDLE) && head.valid;
  assign done = (state == ST_LOOK) && (!out_valid || pop);
  assign is_acc = (work.func != FUNC_IFETCH);

  always_comb begin
    if (ways_in_use == '0) begin
      nways = NWAYS_W'(1);
    end else if (NWAYS_W'(ways_in_use) > NWAYS_W'(WAYS)) begin
      nways = NWAYS_W'(WAYS);
    end else begin
      nways = NWAYS_W'(ways_in_use);
    end
    vrow = valid[work.set_idx];
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (NWAYS_W'(w) < nways);
      rank[w] = rank_row[w*RANK_W +: RANK_W];
      hit_vec[w] = in_use[w] && vrow[w] && (tag_row[w*ADDR_WIDTH +: ADDR_WIDTH] == work.tag);
    end
    hit = |hit_vec;

    // Lowest matching way and lowest free way win.
    hit_way = '0;
    empty_way = '0;
    found_empty = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !vrow[w]) begin
        empty_way = WAY_W'(w);
        found_empty = 1'b1;
      end
    end

    // Oldest way in use; strict compare keeps the lowest on a tie.
    max_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (rank[w] > rank[max_way])) begin
        max_way = WAY_W'(w);
      end
    end

    hit_rank = rank[hit_way];
    evict = !hit && !found_empty;
    if (hit) begin
      target = hit_way;
    end else if (found_empty) begin
      target = empty_way;
    end else begin
      target = max_way;
    end

    tag_new = tag_row;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        rank_new[w*RANK_W +: RANK_W] = '0;
        tag_new[w*ADDR_WIDTH +: ADDR_WIDTH] = work.tag;
      end else if (in_use[w] && vrow[w] && (rank[w] < RANK_MAX) &&
                   (!hit || (rank[w] < hit_rank))) begin
        rank_new[w*RANK_W +: RANK_W] = rank[w] + 1'b1;
      end else begin
        rank_new[w*RANK_W +: RANK_W] = rank[w];
      end
    end

    hits_next = (is_acc && hit) ? sat_inc(hits) : hits;
    if (work.func == FUNC_MODIFY) begin
      // The second access lands on the line just made most recent.
      hits_next = sat_inc(hits_next);
    end
    misses_next = (is_acc && !hit) ? sat_inc(misses) : misses;
    evicts_next = (is_acc && evict) ? sat_inc(evicts) : evicts;

    rsp_next.was_hit = is_acc && hit;
    rsp_next.was_miss = is_acc && !hit;
    rsp_next.was_evict = is_acc && evict;
    rsp_next.second_hit = (work.func == FUNC_MODIFY);
    rsp_next.total_hits = hits_next;
    rsp_next.total_misses = misses_next;
    rsp_next.total_evictions = evicts_next;
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      work <= head.item;
      tag_row <= tag_mem[head.item.set_idx];
      rank_row <= rank_mem[head.item.set_idx];
    end
    if (done && is_acc) begin
      rank_mem[work.set_idx] <= rank_new;
      if (!hit) begin
        tag_mem[work.set_idx] <= tag_new;
      end
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      hits <= '0;
      misses <= '0;
      evicts <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid[s] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (done) begin
        out_valid <= 1'b1;
        hits <= hits_next;
        misses <= misses_next;
        evicts <= evicts_next;
        if (is_acc && !hit) begin
          valid[work.set_idx][target] <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule
